// ----- hw/rtl/wsc_pkg.sv -----
`default_nettype none

package wsc_pkg;

    typedef enum logic [1:0] {
        OP_WRITE       = 2'd0,
        OP_READ        = 2'd1,
        OP_FREQ_TICK   = 2'd2,
        OP_LENGTH_TICK = 2'd3
    } op_t;

    localparam logic [15:0] ADDR_NR30      = 16'hFF1A;
    localparam logic [15:0] ADDR_NR31      = 16'hFF1B;
    localparam logic [15:0] ADDR_NR32      = 16'hFF1C;
    localparam logic [15:0] ADDR_NR33      = 16'hFF1D;
    localparam logic [15:0] ADDR_NR34      = 16'hFF1E;
    localparam logic [11:0] WAVE_BASE_HIGH = 12'hFF3;

    localparam int unsigned WAVE_BYTES = 16;
    localparam int unsigned WAVE_AW    = $clog2(WAVE_BYTES);

    localparam logic [12:0] PERIOD_RESET = 13'd64;
    localparam logic [11:0] FREQ_SPAN    = 12'd2048;
    localparam logic [8:0]  LENGTH_FULL  = 9'h100;
    localparam logic [8:0]  LENGTH_MAX   = 9'h0FF;
    localparam logic [7:0]  NR30_FILL    = 8'h7F;
    localparam logic [7:0]  NR32_FILL    = 8'h9F;
    localparam logic [7:0]  NR34_FILL    = 8'hBF;
    localparam logic [7:0]  OPEN_BUS     = 8'hFF;

    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] sample_out;
        logic       running;
    } result_t;

endpackage : wsc_pkg

`default_nettype wire

// ----- hw/rtl/wave_sound_channel.sv -----
// Each accepted word's result is registered in the output buffer; one word per cycle is taken
// while in_stall is low. Every operation is one pass through the register file logic.
// A two-entry output buffer lets input words flow while one result waits to be taken.
// Reset is asynchronous and active low: channel registers take their power-on values,
// the period counter loads 64 and the output buffer empties. Wave memory is not reset.
`default_nettype none

module wave_sound_channel (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output      logic                     in_stall,
    input  wire logic [1:0]               operation,
    input  wire logic [15:0]              address,
    input  wire logic [7:0]               write_data,
    output      logic                     out_valid,
    input  wire logic                     out_stall,
    output      logic [7:0]               read_data,
    output      logic [3:0]               sample_out,
    output      logic                     running
);
    import wsc_pkg::*;

    logic        dac_enable_reg, dac_enable_next;
    logic        active_reg, active_next;
    logic [1:0]  volume_code_reg, volume_code_next;
    logic [10:0] freq_value_reg, freq_value_next;
    logic [12:0] period_timer_reg, period_timer_next;
    logic [4:0]  sample_position_reg, sample_position_next;
    logic [8:0]  length_left_reg, length_left_next;
    logic        length_enable_reg, length_enable_next;
    logic [3:0]  current_sample_reg, current_sample_next;
    logic [3:0]  output_level_reg, output_level_next;

    logic [7:0]  wave_mem [WAVE_BYTES];

    result_t     main_reg, skid_reg, result;
    logic        main_valid_reg, skid_valid_reg;

    op_t              op;
    logic             accept, pop;
    logic             wave_hit, wave_we;
    logic [WAVE_AW-1:0] wave_index;
    logic [7:0]       wave_byte;
    logic [12:0]      period_dec, new_period;
    logic [4:0]       next_position;
    logic [3:0]       nibble, scaled;
    logic [10:0]      freq_merged;
    logic [8:0]       length_dec;
    logic             on_now, on_next;

    assign op       = op_t'(operation);
    assign accept   = in_valid && !in_stall;
    assign pop      = main_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    assign wave_hit      = (address[15:4] == WAVE_BASE_HIGH);
    assign period_dec    = (period_timer_reg != 13'd0) ? period_timer_reg - 13'd1 : 13'd0;
    assign next_position = sample_position_reg + 5'd1;
    assign on_now        = active_reg && dac_enable_reg;

    // The bus read and the sample fetch never happen for the same word, so one
    // read index serves both.
    assign wave_index = (op == OP_READ) ? address[WAVE_AW-1:0] : next_position[4:1];
    assign wave_byte  = wave_mem[wave_index];
    assign nibble     = next_position[0] ? wave_byte[3:0] : wave_byte[7:4];

    always_comb
    begin
        case (volume_code_reg)
            2'd0:    scaled = 4'd0;
            2'd1:    scaled = nibble;
            2'd2:    scaled = nibble >> 1;
            default: scaled = nibble >> 2;
        endcase
    end

    // On a trigger the period follows the frequency as just written.
    assign freq_merged = {write_data[2:0], freq_value_reg[7:0]};
    assign new_period  = {(FREQ_SPAN - {1'b0, (op == OP_WRITE && address == ADDR_NR34)
                                        ? freq_merged : freq_value_reg}), 1'b0};
    assign length_dec  = (length_left_reg != 9'd0) ? length_left_reg - 9'd1 : 9'd0;

    always_comb
    begin
        dac_enable_next      = dac_enable_reg;
        active_next          = active_reg;
        volume_code_next     = volume_code_reg;
        freq_value_next      = freq_value_reg;
        period_timer_next    = period_timer_reg;
        sample_position_next = sample_position_reg;
        length_left_next     = length_left_reg;
        length_enable_next   = length_enable_reg;
        current_sample_next  = current_sample_reg;
        output_level_next    = output_level_reg;
        wave_we              = 1'b0;
        result.read_data     = OPEN_BUS;

        case (op)
            OP_WRITE:
            begin
                if (address == ADDR_NR30)
                begin
                    dac_enable_next = write_data[7];
                    if (!write_data[7])
                        active_next = 1'b0;
                end
                else if (address == ADDR_NR31)
                begin
                    length_left_next = (write_data == 8'd0) ? LENGTH_MAX
                                       : LENGTH_FULL - {1'b0, write_data};
                end
                else if (address == ADDR_NR32)
                begin
                    volume_code_next = write_data[6:5];
                end
                else if (address == ADDR_NR33)
                begin
                    freq_value_next = {freq_value_reg[10:8], write_data};
                end
                else if (address == ADDR_NR34)
                begin
                    length_enable_next = write_data[6];
                    freq_value_next    = freq_merged;
                    if (write_data[7])
                    begin
                        active_next          = 1'b1;
                        period_timer_next    = new_period;
                        sample_position_next = 5'd0;
                        if (length_left_reg == 9'd0)
                            length_left_next = LENGTH_MAX;
                    end
                end
                else if (wave_hit)
                begin
                    wave_we = 1'b1;
                end
            end
            OP_READ:
            begin
                if (address == ADDR_NR30)
                    result.read_data = {dac_enable_reg, 7'd0} | NR30_FILL;
                else if (address == ADDR_NR32)
                    result.read_data = {1'b0, volume_code_reg, 5'd0} | NR32_FILL;
                else if (address == ADDR_NR34)
                    result.read_data = {1'b0, length_enable_reg, 6'd0} | NR34_FILL;
                else if (wave_hit)
                    result.read_data = wave_byte;
            end
            OP_FREQ_TICK:
            begin
                period_timer_next = period_dec;
                if (period_dec == 13'd0)
                begin
                    period_timer_next    = new_period;
                    sample_position_next = next_position;
                    if (on_now)
                        current_sample_next = scaled;
                end
                output_level_next = on_now ? current_sample_next : 4'd0;
            end
            default:
            begin
                if (length_enable_reg)
                begin
                    length_left_next = length_dec;
                    if (length_dec == 9'd0)
                        active_next = 1'b0;
                end
            end
        endcase

        on_next           = active_next && dac_enable_next;
        result.sample_out = on_next ? output_level_next : 4'd0;
        result.running    = on_next && (length_left_next != 9'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dac_enable_reg      <= 1'b0;
            active_reg          <= 1'b0;
            volume_code_reg     <= 2'd0;
            freq_value_reg      <= 11'd0;
            period_timer_reg    <= PERIOD_RESET;
            sample_position_reg <= 5'd0;
            length_left_reg     <= 9'd0;
            length_enable_reg   <= 1'b0;
            current_sample_reg  <= 4'd0;
            output_level_reg    <= 4'd0;
        end
        else if (accept)
        begin
            dac_enable_reg      <= dac_enable_next;
            active_reg          <= active_next;
            volume_code_reg     <= volume_code_next;
            freq_value_reg      <= freq_value_next;
            period_timer_reg    <= period_timer_next;
            sample_position_reg <= sample_position_next;
            length_left_reg     <= length_left_next;
            length_enable_reg   <= length_enable_next;
            current_sample_reg  <= current_sample_next;
            output_level_reg    <= output_level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && wave_we)
            wave_mem[address[WAVE_AW-1:0]] <= write_data;
    end

    // Output buffer: the main register faces the port, the skid register holds
    // a word that arrived while the main one was stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            if (main_valid_reg)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
                main_reg <= skid_reg;
            else if (accept)
                main_reg <= result;
        end
        else if (accept)
        begin
            if (main_valid_reg)
                skid_reg <= result;
            else
                main_reg <= result;
        end
    end

    assign out_valid  = main_valid_reg;
    assign read_data  = main_reg.read_data;
    assign sample_out = main_reg.sample_out;
    assign running    = main_reg.running;

    skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid register holds a word while the output register is empty");

    period_never_zero: assert property (@(posedge clk) disable iff (!rst_n)
        period_timer_reg != 13'd0)
        else $error("period counter rests at zero");

    accept_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !main_valid_reg) |=> main_valid_reg)
        else $error("accepted word did not reach the output register");

    length_expiry_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_LENGTH_TICK && length_enable_reg && length_left_reg == 9'd1)
        |=> !active_reg)
        else $error("channel still active after its length ran out");

endmodule : wave_sound_channel

`default_nettype wire
